// ===== rtl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Types, codes and constants shared by the count-min sketch modules.
// ----------------------------------------------------------------------------
package cms_pkg;

	localparam int MAX_ROWS_DEF = 4;
	localparam int MAX_COLS_DEF = 1024;

	localparam logic [31:0] MM_C1    = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2    = 32'h1b873593;
	localparam logic [31:0] MM_ADD   = 32'he6546b64;
	localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
	localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;

	localparam logic [10:0] COLS_RESET = 11'd1024;
	localparam logic [2:0]  ROWS_RESET = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef enum logic [1:0] {
		OPC_UPDATE   = 2'd0,
		OPC_ESTIMATE = 2'd1,
		OPC_CLEAR    = 2'd2,
		OPC_RSVD     = 2'd3
	} cms_opc_e;

	typedef enum logic [3:0] {
		C_NONE,
		C_ABS_FULL,
		C_ABS_TAIL,
		C_FIN0,
		C_FIN1,
		C_FIN2,
		C_FIN3,
		C_MOD,
		C_SEED,
		C_WR,
		C_CLR,
		C_CLR_ALL,
		C_CHAIN
	} cms_cell_op_e;

	typedef struct packed {
		cms_cell_op_e code;
		logic [31:0]  k;
		logic [31:0]  len;
	} cms_cmd_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_MIX1,
		S_MIX2,
		S_ABS,
		S_FIN0,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_MOD,
		S_RD,
		S_WR,
		S_CHAIN,
		S_CLR,
		S_DONE
	} cms_state_e;

endpackage

// ===== rtl/cms_cell.sv =====
// ----------------------------------------------------------------------------
// cms_cell
// One sketch row: hash state, serial modulo, counter bank and a min stage.
// ----------------------------------------------------------------------------
module cms_cell #(
	parameter int ROW_IDX     = 0,
	parameter int MAX_COLUMNS = cms_pkg::MAX_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cms_pkg::cms_cmd_t              cmd,
	input  logic                           row_en,
	input  logic [$clog2(MAX_COLUMNS)-1:0] clr_addr,
	input  logic [$clog2(MAX_COLUMNS):0]   cols,
	input  logic [31:0]                    count,
	input  logic [31:0]                    min_in,
	output logic [31:0]                    min_out,
	output logic [$clog2(MAX_COLUMNS)-1:0] pos
);

	localparam int AW = $clog2(MAX_COLUMNS);

	logic [31:0]   hash_q;
	logic [AW:0]   rem_q;
	logic [31:0]   rd_q;
	logic [31:0]   min_q;
	logic [31:0]   mem [MAX_COLUMNS];
	logic [31:0]   mix_t;
	logic [31:0]   rot_t;
	logic [31:0]   fin_t;
	logic [AW:0]   rem_sh;

	always_comb begin
		mix_t  = hash_q ^ cmd.k;
		rot_t  = {mix_t[18:0], mix_t[31:19]};
		fin_t  = hash_q ^ cmd.len;
		rem_sh = {rem_q[AW-1:0], hash_q[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 32'(ROW_IDX);
		end else begin
			case (cmd.code)
				cms_pkg::C_ABS_FULL: hash_q <= (rot_t << 2) + rot_t + cms_pkg::MM_ADD;
				cms_pkg::C_ABS_TAIL: hash_q <= mix_t;
				cms_pkg::C_FIN0:     hash_q <= fin_t ^ (fin_t >> 16);
				cms_pkg::C_FIN1:     hash_q <= hash_q * cms_pkg::FMIX_C1;
				cms_pkg::C_FIN2:     hash_q <= (hash_q ^ (hash_q >> 13)) * cms_pkg::FMIX_C2;
				cms_pkg::C_FIN3:     hash_q <= hash_q ^ (hash_q >> 16);
				cms_pkg::C_MOD:      hash_q <= hash_q << 1;
				cms_pkg::C_SEED:     hash_q <= 32'(ROW_IDX);
				default:             hash_q <= hash_q;
			endcase
		end
	end

	// Restoring remainder, one hash bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (cmd.code == cms_pkg::C_FIN3) begin
			rem_q <= '0;
		end else if (cmd.code == cms_pkg::C_MOD) begin
			rem_q <= (rem_sh >= cols) ? rem_sh - cols : rem_sh;
		end
		if (cmd.code == cms_pkg::C_CHAIN) begin
			min_q <= (row_en && rd_q < min_in) ? rd_q : min_in;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rem_q[AW-1:0]];
		if (cmd.code == cms_pkg::C_WR && row_en) begin
			mem[rem_q[AW-1:0]] <= rd_q + count;
		end else if ((cmd.code == cms_pkg::C_CLR && row_en) ||
				cmd.code == cms_pkg::C_CLR_ALL) begin
			mem[clr_addr] <= '0;
		end
	end

	assign min_out = min_q;
	assign pos     = rem_q[AW-1:0];

endmodule

// ===== rtl/count_min_sketch_top.sv =====
// ----------------------------------------------------------------------------
// count_min_sketch_top
// Count-min sketch with per-row MurmurHash3 x86_32 over streamed key words.
// ----------------------------------------------------------------------------
// A key word passes through capture, two mixing multiplies and an absorb into
// every row cell. On the last word the finalize steps, a bit-serial modulo over
// all 32 hash bits in each cell and one counter read follow, then one write
// for an update or, for an estimate, the minimum ripples down the whole row
// chain; the result register is then loaded once the output slot is free. A
// clear sweeps the columns in use, one column of every row in use per cycle.
// After reset the block clears the counters of all rows in every column before
// it takes the first transaction.
module count_min_sketch_top #(
	parameter int MAX_ROWS    = cms_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = cms_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] key_word,
	input  logic [2:0]  key_bytes,
	input  logic        last,
	input  logic [31:0] count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] estimate,
	output logic [9:0]  first_row_pos,
	output logic [31:0] total_count
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = AW + 1;
	localparam int SW = (CW > 6) ? CW : 6;
	localparam int RW = $clog2(MAX_ROWS + 1);

	cms_pkg::cms_state_e state_q, state_d;
	logic [SW-1:0]       step_q, step_d;
	cms_pkg::cms_cmd_t   cmd;

	logic [10:0] col_cfg_q;
	logic [2:0]  row_cfg_q;
	logic [CW-1:0] cols_eff;
	logic [RW-1:0] rows_eff;
	logic [MAX_ROWS-1:0] row_en;

	logic [1:0]  op_q;
	logic [31:0] word_q;
	logic [2:0]  nb_q;
	logic        last_q;
	logic [31:0] count_q;
	logic [31:0] k1_q, k_q;
	logic [31:0] len_q, total_q;

	logic [2:0]  nb_eff;
	logic [31:0] word_mask;
	logic [31:0] k1_rot;
	logic        slot_free;

	logic        out_valid_q;
	logic [31:0] estimate_q, total_out_q;
	logic [9:0]  pos_out_q;
	logic [31:0] pos0_ext;

	logic [31:0] min_w [MAX_ROWS+1];
	logic [AW-1:0] pos_w [MAX_ROWS];

	always_comb begin
		if (col_cfg_q == '0) begin
			cols_eff = CW'(1);
		end else if (32'(col_cfg_q) > 32'(MAX_COLUMNS)) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(col_cfg_q);
		end
		if (row_cfg_q == '0) begin
			rows_eff = RW'(1);
		end else if (32'(row_cfg_q) > 32'(MAX_ROWS)) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(row_cfg_q);
		end
	end

	always_comb begin
		if (!last) begin
			nb_eff = 3'd4;
		end else if (key_bytes > 3'd4) begin
			nb_eff = 3'd4;
		end else begin
			nb_eff = key_bytes;
		end
		case (nb_eff)
			3'd0:    word_mask = 32'h0000_0000;
			3'd1:    word_mask = 32'h0000_00ff;
			3'd2:    word_mask = 32'h0000_ffff;
			3'd3:    word_mask = 32'h00ff_ffff;
			default: word_mask = 32'hffff_ffff;
		endcase
		k1_rot = {k1_q[16:0], k1_q[31:17]};
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd.code = cms_pkg::C_NONE;
		cmd.k    = k_q;
		cmd.len  = len_q;
		case (state_q)
			cms_pkg::S_INIT: begin
				cmd.code = cms_pkg::C_CLR_ALL;
				if (step_q == SW'(MAX_COLUMNS - 1)) begin
					state_d = cms_pkg::S_IDLE;
					step_d  = '0;
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			cms_pkg::S_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					case (op)
						cms_pkg::OPC_CLEAR: state_d = cms_pkg::S_CLR;
						cms_pkg::OPC_RSVD:  state_d = cms_pkg::S_IDLE;
						default:            state_d = cms_pkg::S_MIX1;
					endcase
				end
			end
			cms_pkg::S_MIX1: state_d = cms_pkg::S_MIX2;
			cms_pkg::S_MIX2: state_d = cms_pkg::S_ABS;
			cms_pkg::S_ABS: begin
				if (nb_q == 3'd4) begin
					cmd.code = cms_pkg::C_ABS_FULL;
				end else if (nb_q != 3'd0) begin
					cmd.code = cms_pkg::C_ABS_TAIL;
				end
				state_d = last_q ? cms_pkg::S_FIN0 : cms_pkg::S_IDLE;
			end
			cms_pkg::S_FIN0: begin
				cmd.code = cms_pkg::C_FIN0;
				state_d  = cms_pkg::S_FIN1;
			end
			cms_pkg::S_FIN1: begin
				cmd.code = cms_pkg::C_FIN1;
				state_d  = cms_pkg::S_FIN2;
			end
			cms_pkg::S_FIN2: begin
				cmd.code = cms_pkg::C_FIN2;
				state_d  = cms_pkg::S_FIN3;
			end
			cms_pkg::S_FIN3: begin
				cmd.code = cms_pkg::C_FIN3;
				state_d  = cms_pkg::S_MOD;
				step_d   = '0;
			end
			cms_pkg::S_MOD: begin
				cmd.code = cms_pkg::C_MOD;
				if (step_q == SW'(31)) begin
					state_d = cms_pkg::S_RD;
					step_d  = '0;
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			cms_pkg::S_RD: begin
				state_d = (op_q == cms_pkg::OPC_UPDATE) ? cms_pkg::S_WR : cms_pkg::S_CHAIN;
			end
			cms_pkg::S_WR: begin
				cmd.code = cms_pkg::C_WR;
				state_d  = cms_pkg::S_DONE;
			end
			cms_pkg::S_CHAIN: begin
				cmd.code = cms_pkg::C_CHAIN;
				if (step_q == SW'(MAX_ROWS - 1)) begin
					state_d = cms_pkg::S_DONE;
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			cms_pkg::S_CLR: begin
				cmd.code = cms_pkg::C_CLR;
				if (step_q == SW'(cols_eff) - SW'(1)) begin
					state_d = cms_pkg::S_DONE;
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			cms_pkg::S_DONE: begin
				if (slot_free) begin
					cmd.code = cms_pkg::C_SEED;
					state_d  = cms_pkg::S_IDLE;
				end
			end
			default: state_d = cms_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cms_pkg::S_INIT;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cfg_q   <= cms_pkg::COLS_RESET;
			row_cfg_q   <= cms_pkg::ROWS_RESET;
			len_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					cms_pkg::CFG_COLS: col_cfg_q <= cfg_data;
					cms_pkg::CFG_ROWS: row_cfg_q <= cfg_data[2:0];
					default:           col_cfg_q <= col_cfg_q;
				endcase
			end
			if (state_q == cms_pkg::S_ABS) begin
				len_q <= len_q + 32'(nb_q);
				if (last_q && op_q == cms_pkg::OPC_UPDATE) begin
					total_q <= total_q + count_q;
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == cms_pkg::S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
				len_q       <= '0;
			end
		end
	end

	assign pos0_ext = 32'(pos_w[0]);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			word_q  <= key_word & word_mask;
			nb_q    <= nb_eff;
			last_q  <= last;
			count_q <= count;
		end
		if (state_q == cms_pkg::S_MIX1) begin
			k1_q <= word_q * cms_pkg::MM_C1;
		end
		if (state_q == cms_pkg::S_MIX2) begin
			k_q <= k1_rot * cms_pkg::MM_C2;
		end
		if (state_q == cms_pkg::S_DONE && slot_free) begin
			estimate_q  <= (op_q == cms_pkg::OPC_ESTIMATE) ? min_w[MAX_ROWS] : 32'd0;
			pos_out_q   <= (op_q == cms_pkg::OPC_CLEAR) ? 10'd0 : pos0_ext[9:0];
			total_out_q <= total_q;
		end
	end

	assign min_w[0] = '1;

	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
		assign row_en[r] = (32'(r) < 32'(rows_eff));
		cms_cell #(
			.ROW_IDX     (r),
			.MAX_COLUMNS (MAX_COLUMNS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.row_en   (row_en[r]),
			.clr_addr (step_q[AW-1:0]),
			.cols     (cols_eff),
			.count    (count_q),
			.min_in   (min_w[r]),
			.min_out  (min_w[r+1]),
			.pos      (pos_w[r])
		);
	end

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == cms_pkg::S_IDLE);
	assign out_valid     = out_valid_q;
	assign estimate      = estimate_q;
	assign first_row_pos = pos_out_q;
	assign total_count   = total_out_q;

`ifndef NO_ASSERTIONS
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cms_pkg::S_DONE && slot_free) |=> out_valid_q)
		else $error("result not presented after completion");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cms_pkg::S_DONE))
		else $error("result presented outside completion");

	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cms_pkg::S_INIT) |-> !in_ready)
		else $error("input taken during counter clearing");

	a_mod_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cms_pkg::S_MOD && step_q != SW'(31)) |=> (state_q == cms_pkg::S_MOD))
		else $error("modulo ended early");
`endif

endmodule
